// ===== src/tsfr_pkg.sv =====
package tsfr_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_ACK   = 2'd3
    } t_opcode;

    // Word register indices
    localparam logic [7:0] IDX_STOPWATCH  = 8'd6;
    localparam logic [7:0] IDX_COMM_BASE  = 8'd16;
    localparam logic [7:0] IDX_TIMER      = 8'd24;
    localparam logic [7:0] IDX_IRQ_MASK   = 8'd25;
    localparam logic [7:0] IDX_FONT_COLOR = 8'd38;
    localparam logic [7:0] IDX_FONT_BITS  = 8'd39;
    localparam logic [7:0] IDX_FONT_DATA0 = 8'd40;
    localparam logic [7:0] IDX_FONT_DATA3 = 8'd43;

    // Writable interrupt mask bits and the timer enable bit among them
    localparam logic [15:0] IRQ_MASK_BITS = 16'h007E;
    localparam int          TIMER_IRQ_POS = 3;

    // One input transaction
    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  reg_index;
        logic [15:0] write_data;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [15:0] read_data;
        logic        timer_irq;
    } t_result;

endpackage

// ===== src/tsfr_core.sv =====
module tsfr_core
    import tsfr_pkg::*;
#(
    parameter int COMM_WORDS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int CW = (COMM_WORDS > 1) ? $clog2(COMM_WORDS) : 1;

    logic [11:0] r_stopwatch, n_stopwatch;
    logic [7:0]  r_reload,    n_reload;
    logic [7:0]  r_count,     n_count;
    logic        r_pending,   n_pending;
    logic [15:0] r_mask,      n_mask;
    logic [7:0]  r_colors,    n_colors;
    logic [15:0] r_pattern,   n_pattern;
    logic [15:0] r_comm [COMM_WORDS];

    logic [7:0]    comm_off;
    logic          comm_hit;
    logic [CW-1:0] comm_sel;
    logic [3:0]    font_bits;
    logic [15:0]   font_word;
    logic [15:0]   rd;
    logic          comm_we;

    // Comm status window decode
    assign comm_off = i_item.reg_index - IDX_COMM_BASE;
    assign comm_hit = (i_item.reg_index >= IDX_COMM_BASE) && (comm_off < 8'(COMM_WORDS));
    assign comm_sel = comm_off[CW-1:0];

    // Font data expansion: data word k takes pattern nibble 3-k
    always_comb begin
        unique case (i_item.reg_index[1:0])
            2'd0: font_bits = r_pattern[15:12];
            2'd1: font_bits = r_pattern[11:8];
            2'd2: font_bits = r_pattern[7:4];
            default: font_bits = r_pattern[3:0];
        endcase
        for (int i = 0; i < 4; i++) begin
            font_word[4*i +: 4] = font_bits[i] ? r_colors[7:4] : r_colors[3:0];
        end
    end

    // Register read mux; fixed registers win over the comm window
    always_comb begin
        priority if (i_item.reg_index == IDX_STOPWATCH) begin
            rd = {4'd0, r_stopwatch};
        end else if (i_item.reg_index == IDX_TIMER) begin
            rd = {8'd0, r_reload};
        end else if (i_item.reg_index == IDX_IRQ_MASK) begin
            rd = r_mask;
        end else if (i_item.reg_index == IDX_FONT_COLOR) begin
            rd = {8'd0, r_colors};
        end else if (i_item.reg_index == IDX_FONT_BITS) begin
            rd = r_pattern;
        end else if (i_item.reg_index >= IDX_FONT_DATA0
                     && i_item.reg_index <= IDX_FONT_DATA3) begin
            rd = font_word;
        end else if (comm_hit) begin
            rd = r_comm[comm_sel];
        end else begin
            rd = 16'd0;
        end
    end

    // Next state for one transaction
    always_comb begin
        n_stopwatch = r_stopwatch;
        n_reload    = r_reload;
        n_count     = r_count;
        n_pending   = r_pending;
        n_mask      = r_mask;
        n_colors    = r_colors;
        n_pattern   = r_pattern;
        comm_we     = 1'b0;
        unique case (i_item.opcode)
            OP_TICK: begin
                n_stopwatch = r_stopwatch + 12'd1;
                if (r_count == 8'd0) begin
                    n_count = r_reload;
                end else begin
                    n_count = r_count - 8'd1;
                    if (r_count == 8'd1) n_pending = 1'b1;
                end
            end
            OP_READ: begin
            end
            OP_WRITE: begin
                priority if (i_item.reg_index == IDX_STOPWATCH) begin
                    n_stopwatch = 12'd0;
                end else if (i_item.reg_index == IDX_TIMER) begin
                    n_reload = i_item.write_data[7:0];
                end else if (i_item.reg_index == IDX_IRQ_MASK) begin
                    n_mask = i_item.write_data & IRQ_MASK_BITS;
                end else if (i_item.reg_index == IDX_FONT_COLOR) begin
                    n_colors = i_item.write_data[7:0];
                end else if (i_item.reg_index == IDX_FONT_BITS) begin
                    n_pattern = i_item.write_data;
                end else if (comm_hit && !(i_item.reg_index >= IDX_FONT_DATA0
                                           && i_item.reg_index <= IDX_FONT_DATA3)) begin
                    comm_we = 1'b1;
                end else begin
                end
            end
            OP_ACK: begin
                n_pending = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after this transaction
    assign o_result.read_data = (i_item.opcode == OP_READ) ? rd : 16'd0;
    assign o_result.timer_irq = n_pending & n_mask[TIMER_IRQ_POS];

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopwatch <= '0;
            r_reload    <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_mask      <= '0;
            r_colors    <= '0;
            r_pattern   <= '0;
            for (int i = 0; i < COMM_WORDS; i++) r_comm[i] <= '0;
        end else if (i_step) begin
            r_stopwatch <= n_stopwatch;
            r_reload    <= n_reload;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_mask      <= n_mask;
            r_colors    <= n_colors;
            r_pattern   <= n_pattern;
            if (comm_we) r_comm[comm_sel] <= i_item.write_data;
        end
    end

    // Pending only rises on a tick that brings the count from one to zero
    a_pending_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> $past(i_step && i_item.opcode == OP_TICK && r_count == 8'd1))
        else $error("timer pending set without expiry");

    // An acknowledge always leaves pending clear
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.opcode == OP_ACK |=> !r_pending)
        else $error("pending survived acknowledge");

    // A zero reload never lets the count leave zero
    a_zero_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.opcode == OP_TICK && r_reload == 8'd0 && r_count == 8'd0
        |=> r_count == 8'd0 && r_pending == $past(r_pending))
        else $error("disabled timer moved");

endmodule

// ===== src/timer_stopwatch_font_registers_unit.sv =====
// Sub-side register slice: timer tick, word read, word write and timer
// acknowledge transactions, one accepted per cycle when the result side does
// not stall. Each transaction passes an input register, then updates the
// register state and is captured in the result register, so throughput is one
// transaction per cycle when the result side does not stall. Every transaction
// yields exactly one result: read data (zero for non-reads) and the timer
// interrupt line as it stands after that transaction.
module timer_stopwatch_font_registers_unit
    import tsfr_pkg::*;
#(
    parameter int COMM_WORDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_reg_index,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic        o_timer_irq
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    logic    out_ready;
    logic    step;

    // Pipeline flow control
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.opcode     <= t_opcode'(i_opcode);
            r_item.reg_index  <= i_reg_index;
            r_item.write_data <= i_write_data;
        end
    end

    tsfr_core #(
        .COMM_WORDS(COMM_WORDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_result(core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_result <= core_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_result.read_data;
    assign o_timer_irq = r_result.timer_irq;

    // Input side stalls only while a held transaction cannot move on
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule
